/* hdl/asc128_pkg.sv */
// ============================================================================
// asc128_pkg
// Shared types, codes and helper functions of the Ascon-128 AEAD core:
// the permutation round, byte masks and padding, and the interface codes.
// ============================================================================
`default_nettype none

package asc128_pkg;

	typedef logic [4:0][63:0] lanes_t;

	// Item operations on the input channel.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_AD    = 2'd1;
	localparam logic [1:0] OP_TEXT  = 2'd2;
	localparam logic [1:0] OP_TAG   = 2'd3;

	// Result kinds on the output channel.
	localparam logic [1:0] KIND_TEXT    = 2'd0;
	localparam logic [1:0] KIND_FINAL   = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;
	localparam logic [1:0] KIND_SEQ_ERR = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'd1;

	localparam logic [63:0] ASCON_IV   = 64'h80400c0600000000;
	localparam logic [3:0]  FULL_BYTES = 4'd8;
	localparam logic [3:0]  ROUND_FIRST_INIT = 4'd0;
	localparam logic [3:0]  ROUND_FIRST_DATA = 4'd6;
	localparam logic [3:0]  ROUND_LAST = 4'd11;

	function automatic logic [63:0] rotr(logic [63:0] v, int unsigned n);
		return (v >> n) | (v << (64 - n));
	endfunction

	// One round of the permutation; rc is the round constant byte.
	function automatic lanes_t asc_round(lanes_t s, logic [7:0] rc);
		logic [63:0] x0, x1, x2, x3, x4;
		logic [63:0] t0, t1, t2, t3, t4;
		lanes_t r;
		x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
		x2 = x2 ^ {56'd0, rc};
		x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
		t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
		x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
		x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
		r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
		r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
		r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
		r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
		r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
		return r;
	endfunction

	// Mask of the leading n bytes, n from 0 to 8.
	function automatic logic [63:0] lead_mask(logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < n) begin
				m[63-8*b -: 8] = 8'hff;
			end
		end
		return m;
	endfunction

	// Padding byte placed right after the leading n bytes, n from 0 to 7.
	function automatic logic [63:0] pad_bits(logic [3:0] n);
		logic [63:0] p;
		p = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) == n) begin
				p[63-8*b -: 8] = 8'h80;
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

/* hdl/ascon128_aead_core_top.sv */
// ============================================================================
// ascon128_aead_core_top
// Ascon-128 authenticated encryption core with one shared permutation round.
// ============================================================================
// Usage:
// The key is written through the configuration channel (index 0 upper half,
// index 1 lower half) while the core is idle; cfg_ready is always high.
// Input words carry an op: start with nonce, associated-data block, text
// block or tag to verify. in_ready is high only while the sequencer is idle.
// One permutation round runs per cycle in a single round unit. A start word
// runs 12 rounds after its accept step, a full associated-data or text block
// the shorter data permutation, and a final text block the full permutation;
// when the text word also closes associated data, a closing data permutation
// and a text step come first.
// Results leave through an output register. A new input word is taken while
// a result still waits there; if the receiver stalls and another result is
// ready, the sequencer holds it until the register frees.
// Sequence errors and tag verdicts go via the emit state to the output register.
// After reset the key, the state lanes and all phases are zero/idle and no
// result is pending.
// ============================================================================
`default_nettype none

module ascon128_aead_core_top
	import asc128_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           op,
	input  wire logic                 decrypt,
	input  wire logic [63:0]          word_first,
	input  wire logic [63:0]          word_second,
	input  wire logic [3:0]           byte_count,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                kind,
	output logic [63:0]               text,
	output logic [3:0]                text_bytes,
	output logic [63:0]               tag_high,
	output logic [63:0]               tag_low,
	output logic                      tag_ok
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PERM = 4'b0010,
		ST_TEXT = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_AD   = 2'd1,
		PH_TEXT = 2'd2,
		PH_TAG  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		JOB_INIT  = 3'd0,
		JOB_AD    = 3'd1,
		JOB_CLOSE = 3'd2,
		JOB_TEXT  = 3'd3,
		JOB_FINAL = 3'd4
	} job_t;

	state_t      state_q, state_d;
	phase_t      phase_q, phase_d;
	job_t        job_q, job_d;
	logic        dec_q, dec_d;
	logic        ad_seen_q, ad_seen_d;
	logic [3:0]  rnd_q, rnd_d;
	lanes_t      lanes_q, lanes_d;
	logic [63:0] key_high_q, key_low_q;

	logic [63:0] data_q, data_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [1:0]  pend_kind_q, pend_kind_d;
	logic [63:0] pend_text_q, pend_text_d;
	logic [3:0]  pend_bytes_q, pend_bytes_d;
	logic        pend_ok_q, pend_ok_d;
	logic        pend_tag_q, pend_tag_d;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [63:0] text_q;
	logic [3:0]  text_bytes_q;
	logic [63:0] tag_high_q, tag_low_q;
	logic        tag_ok_q;

	logic        in_fire;
	logic [3:0]  in_cnt;
	logic [63:0] in_data;
	lanes_t      rnd_lanes, post_lanes;
	logic        rnd_last;
	logic        slot_free, emit_req, emit_fire;
	lanes_t      emit_lanes;

	// Text step operands, shared by the accept path and the step after closing AD.
	logic [3:0]  tx_cnt;
	logic [63:0] tx_data, tx_mask, tx_txt, tx_l0;
	lanes_t      tx_base, tx_lanes;
	logic        tx_full;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign in_cnt    = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
	assign in_data   = word_first & lead_mask(in_cnt);

	assign rnd_lanes = asc_round(lanes_q, {~rnd_q, rnd_q});
	assign rnd_last  = (rnd_q == ROUND_LAST);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		tx_cnt  = (state_q == ST_TEXT) ? cnt_q : in_cnt;
		tx_data = (state_q == ST_TEXT) ? data_q : in_data;
		tx_base = lanes_q;
		// A text word arriving in the AD phase with no AD absorbed only
		// closes the phase by flipping the domain bit.
		if (state_q != ST_TEXT && phase_q == PH_AD) begin
			tx_base[4] = lanes_q[4] ^ 64'd1;
		end
		tx_mask = lead_mask(tx_cnt);
		if (dec_q) begin
			tx_txt = (tx_base[0] ^ tx_data) & tx_mask;
			tx_l0  = (tx_base[0] & ~tx_mask) | tx_data;
		end else begin
			tx_l0  = tx_base[0] ^ tx_data;
			tx_txt = tx_l0 & tx_mask;
		end
		tx_full  = (tx_cnt == FULL_BYTES);
		tx_lanes = tx_base;
		if (tx_full) begin
			tx_lanes[0] = tx_l0;
		end else begin
			tx_lanes[0] = tx_l0 ^ pad_bits(tx_cnt);
			tx_lanes[1] = tx_base[1] ^ key_high_q;
			tx_lanes[2] = tx_base[2] ^ key_low_q;
		end
	end

	// Key and domain additions that follow the last round of a job.
	always_comb begin
		post_lanes = rnd_lanes;
		unique case (job_q)
			JOB_INIT, JOB_FINAL: begin
				post_lanes[3] = rnd_lanes[3] ^ key_high_q;
				post_lanes[4] = rnd_lanes[4] ^ key_low_q;
			end
			JOB_AD: begin
				if (cnt_q != FULL_BYTES) begin
					post_lanes[4] = rnd_lanes[4] ^ 64'd1;
				end
			end
			JOB_CLOSE: begin
				post_lanes[4] = rnd_lanes[4] ^ 64'd1;
			end
			JOB_TEXT: begin
				post_lanes = rnd_lanes;
			end
			default: begin
				post_lanes = rnd_lanes;
			end
		endcase
	end

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		job_d        = job_q;
		dec_d        = dec_q;
		ad_seen_d    = ad_seen_q;
		rnd_d        = rnd_q;
		lanes_d      = lanes_q;
		data_d       = data_q;
		cnt_d        = cnt_q;
		pend_kind_d  = pend_kind_q;
		pend_text_d  = pend_text_q;
		pend_bytes_d = pend_bytes_q;
		pend_ok_d    = pend_ok_q;
		pend_tag_d   = pend_tag_q;
		emit_req     = 1'b0;
		emit_lanes   = lanes_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					data_d       = in_data;
					cnt_d        = in_cnt;
					pend_kind_d  = KIND_SEQ_ERR;
					pend_text_d  = '0;
					pend_bytes_d = '0;
					pend_ok_d    = 1'b0;
					pend_tag_d   = 1'b0;
					unique case (op)
						OP_START: begin
							lanes_d   = {word_second, word_first, key_low_q, key_high_q,
								ASCON_IV};
							dec_d     = decrypt;
							ad_seen_d = 1'b0;
							phase_d   = PH_AD;
							job_d     = JOB_INIT;
							rnd_d     = ROUND_FIRST_INIT;
							state_d   = ST_PERM;
						end
						OP_AD: begin
							if (phase_q != PH_AD) begin
								state_d = ST_EMIT;
							end else if (in_cnt == FULL_BYTES) begin
								lanes_d[0] = lanes_q[0] ^ in_data;
								job_d      = JOB_AD;
								rnd_d      = ROUND_FIRST_DATA;
								state_d    = ST_PERM;
							end else if (in_cnt != 4'd0 || ad_seen_q) begin
								lanes_d[0] = lanes_q[0] ^ in_data ^ pad_bits(in_cnt);
								job_d      = JOB_AD;
								rnd_d      = ROUND_FIRST_DATA;
								state_d    = ST_PERM;
							end else begin
								lanes_d[4] = lanes_q[4] ^ 64'd1;
								phase_d    = PH_TEXT;
							end
						end
						OP_TEXT: begin
							if (phase_q == PH_AD && ad_seen_q) begin
								lanes_d[0] = lanes_q[0] ^ pad_bits(4'd0);
								job_d      = JOB_CLOSE;
								rnd_d      = ROUND_FIRST_DATA;
								state_d    = ST_PERM;
							end else if (phase_q == PH_AD || phase_q == PH_TEXT) begin
								phase_d      = PH_TEXT;
								lanes_d      = tx_lanes;
								pend_text_d  = tx_txt;
								pend_bytes_d = tx_cnt;
								pend_kind_d  = tx_full ? KIND_TEXT : KIND_FINAL;
								pend_tag_d   = !tx_full && !dec_q;
								job_d        = tx_full ? JOB_TEXT : JOB_FINAL;
								rnd_d        = tx_full ? ROUND_FIRST_DATA : ROUND_FIRST_INIT;
								state_d      = ST_PERM;
							end else begin
								state_d = ST_EMIT;
							end
						end
						OP_TAG: begin
							if (phase_q == PH_TAG) begin
								pend_kind_d = KIND_VERDICT;
								pend_ok_d   = (word_first == lanes_q[3]) &&
									(word_second == lanes_q[4]);
								phase_d     = PH_IDLE;
							end
							state_d = ST_EMIT;
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end
			ST_PERM: begin
				rnd_d   = rnd_q + 4'd1;
				lanes_d = rnd_lanes;
				if (rnd_last) begin
					rnd_d   = '0;
					lanes_d = post_lanes;
					unique case (job_q)
						JOB_INIT: begin
							state_d = ST_IDLE;
						end
						JOB_AD: begin
							if (cnt_q == FULL_BYTES) begin
								ad_seen_d = 1'b1;
							end else begin
								phase_d = PH_TEXT;
							end
							state_d = ST_IDLE;
						end
						JOB_CLOSE: begin
							phase_d = PH_TEXT;
							state_d = ST_TEXT;
						end
						JOB_TEXT, JOB_FINAL: begin
							if (job_q == JOB_FINAL) begin
								phase_d = dec_q ? PH_TAG : PH_IDLE;
							end
							emit_req   = 1'b1;
							emit_lanes = post_lanes;
							state_d    = slot_free ? ST_IDLE : ST_EMIT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_TEXT: begin
				lanes_d      = tx_lanes;
				pend_text_d  = tx_txt;
				pend_bytes_d = tx_cnt;
				pend_kind_d  = tx_full ? KIND_TEXT : KIND_FINAL;
				pend_tag_d   = !tx_full && !dec_q;
				pend_ok_d    = 1'b0;
				job_d        = tx_full ? JOB_TEXT : JOB_FINAL;
				rnd_d        = tx_full ? ROUND_FIRST_DATA : ROUND_FIRST_INIT;
				state_d      = ST_PERM;
			end
			ST_EMIT: begin
				emit_req = 1'b1;
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign emit_fire = emit_req && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_IDLE;
			job_q       <= JOB_INIT;
			dec_q       <= 1'b0;
			ad_seen_q   <= 1'b0;
			rnd_q       <= '0;
			lanes_q     <= '0;
			key_high_q  <= '0;
			key_low_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			job_q     <= job_d;
			dec_q     <= dec_d;
			ad_seen_q <= ad_seen_d;
			rnd_q     <= rnd_d;
			lanes_q   <= lanes_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_KEY_HIGH: key_high_q <= cfg_data;
					CFG_KEY_LOW:  key_low_q  <= cfg_data;
					default: begin
						key_high_q <= key_high_q;
					end
				endcase
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q       <= data_d;
		cnt_q        <= cnt_d;
		pend_kind_q  <= pend_kind_d;
		pend_text_q  <= pend_text_d;
		pend_bytes_q <= pend_bytes_d;
		pend_ok_q    <= pend_ok_d;
		pend_tag_q   <= pend_tag_d;
		if (emit_fire) begin
			kind_q       <= pend_kind_q;
			text_q       <= pend_text_q;
			text_bytes_q <= pend_bytes_q;
			tag_ok_q     <= pend_ok_q;
			tag_high_q   <= pend_tag_q ? emit_lanes[3] : 64'd0;
			tag_low_q    <= pend_tag_q ? emit_lanes[4] : 64'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign text       = text_q;
	assign text_bytes = text_bytes_q;
	assign tag_high   = tag_high_q;
	assign tag_low    = tag_low_q;
	assign tag_ok     = tag_ok_q;

endmodule

`default_nettype wire

/* hdl/asc128_chk.sv */
// ============================================================================
// asc128_chk
// Port-level checks of the Ascon-128 AEAD core, bound to the top level.
// ============================================================================
`default_nettype none

module asc128_chk
	import asc128_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  op,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  kind,
	input wire logic [63:0] text,
	input wire logic [3:0]  text_bytes,
	input wire logic [63:0] tag_high,
	input wire logic [63:0] tag_low,
	input wire logic        tag_ok
);

	// A stalled result word holds its kind and text.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(text))
		else $error("result word changed while stalled");

	// A start word always runs the initialization, so the core is busy next.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_START |=> !in_ready)
		else $error("core ready right after a start word");

	// A sequence error carries nothing but its kind.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SEQ_ERR |->
		text == 64'd0 && text_bytes == 4'd0 && tag_high == 64'd0 &&
		tag_low == 64'd0 && !tag_ok)
		else $error("sequence error with nonzero fields");

	// A non-final text word always carries a full block.
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TEXT |-> text_bytes == FULL_BYTES && !tag_ok)
		else $error("text block word with a short byte count");

	// Final text never reports more than a short block.
	a_final_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FINAL |-> text_bytes < FULL_BYTES)
		else $error("final text word with a full byte count");

endmodule

bind ascon128_aead_core_top asc128_chk u_asc128_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.op         (op),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.text       (text),
	.text_bytes (text_bytes),
	.tag_high   (tag_high),
	.tag_low    (tag_low),
	.tag_ok     (tag_ok)
);

`default_nettype wire
